/* hw/rtl/sinc_taylor_series_unit_assert.svh */
// Assertion macros shared by the sinc series unit modules.
`ifndef SINC_TAYLOR_SERIES_UNIT_ASSERT_SVH
`define SINC_TAYLOR_SERIES_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STSU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STSU_ASSERT(lbl, clk, rst, prop, msg)
`define STSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/stsu_pkg.sv */
// Shared types, widths, constants and the reciprocal table of the sinc series unit.
`timescale 1ns / 1ps
`default_nettype none
package stsu_pkg;

   localparam int X_W    = 31;   // Q3.28 argument
   localparam int Y_W    = 32;   // Q1.30 result
   localparam int TC_W   = 4;    // term count register
   localparam int TERM_W = 4;    // term index carried in the command
   localparam int AX_W   = 30;   // |x| after clamping
   localparam int X2_W   = 32;   // x squared, Q4.28
   localparam int MAG_W  = 31;   // term magnitude, Q30
   localparam int P_W    = 35;   // magnitude times x squared, Q30
   localparam int RCP_W  = 32;   // reciprocal, Q0.32
   localparam int PROD_W = P_W + RCP_W;
   localparam int SUM_W  = 34;

   localparam int MAX_TERMS_DEFAULT = 12;
   localparam logic [TC_W-1:0] TERM_COUNT_RESET = 4'd6;

   localparam logic signed [X_W-1:0]   X_LIMIT  = 31'sd843314857;
   localparam logic [MAG_W-1:0]        MAG_ONE  = 31'd1073741824;
   localparam logic signed [SUM_W-1:0] SUM_ONE  = 34'sd1073741824;
   localparam logic signed [Y_W-1:0]   Y_ONE    = 32'sd1073741824;

   typedef struct packed {
      logic              load;
      logic              square;
      logic              mul_x2;
      logic              mul_rcp;
      logic              finish;
      logic [TERM_W-1:0] term;
   } stsu_cmd_type;

   typedef struct packed {
      logic out_free;
   } stsu_status_type;

   // round(2^32 / ((2k)(2k+1)))
   function automatic logic [RCP_W-1:0] recip_q32(input logic [TERM_W-1:0] k);
      logic [RCP_W-1:0] r;
      unique case (k)
         4'd1:    r = 32'd715827883;
         4'd2:    r = 32'd214748365;
         4'd3:    r = 32'd102261126;
         4'd4:    r = 32'd59652324;
         4'd5:    r = 32'd39045157;
         4'd6:    r = 32'd27531842;
         4'd7:    r = 32'd20452225;
         4'd8:    r = 32'd15790321;
         4'd9:    r = 32'd12558384;
         4'd10:   r = 32'd10226113;
         4'd11:   r = 32'd8488078;
         4'd12:   r = 32'd7158279;
         4'd13:   r = 32'd6118187;
         4'd14:   r = 32'd5289369;
         4'd15:   r = 32'd4618244;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/sinc_taylor_series_unit.sv */
// Top level of the sinc(x) Taylor series unit: sequencer plus datapath.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_x_value    Q3.28 signed
//  rsp     | out       | rsp_valid/stall    | rsp_sinc_value Q1.30 signed
//  csr     | in        | csr_valid/ready    | csr_term_count 4 bit
//
// With n terms a beat passes through one squaring step, two passes of the shared multiplier
// per extra term and a final summing step before it leaves.
// The next beat is taken once the result has entered the output register, so the unit
// works on one item at a time.
// Reset is synchronous; it empties the output register and sets the count to 6.
// A stalled result holds the last cycle until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module sinc_taylor_series_unit #(
   parameter int MAX_TERMS = stsu_pkg::MAX_TERMS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [stsu_pkg::X_W-1:0] req_x_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [stsu_pkg::Y_W-1:0]      rsp_sinc_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [stsu_pkg::TC_W-1:0]       csr_term_count
);
   import stsu_pkg::*;

   stsu_cmd_type    cmd;
   stsu_status_type status;

   stsu_ctrl #(
      .MAX_TERMS(MAX_TERMS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_term_count(csr_term_count),
      .status        (status),
      .cmd           (cmd)
   );

   stsu_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_x_value   (req_x_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sinc_value(rsp_sinc_value),
      .cmd           (cmd),
      .status        (status)
   );
endmodule
`default_nettype wire

/* hw/rtl/stsu_ctrl.sv */
// Sequencer for the sinc series unit: term count register and step control.
`timescale 1ns / 1ps
`default_nettype none
`include "sinc_taylor_series_unit_assert.svh"
module stsu_ctrl #(
   parameter int MAX_TERMS = stsu_pkg::MAX_TERMS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [stsu_pkg::TC_W-1:0]  csr_term_count,
   input  wire stsu_pkg::stsu_status_type  status,
   output stsu_pkg::stsu_cmd_type          cmd
);
   import stsu_pkg::*;

   localparam int KW = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;
   localparam int NW = $clog2(MAX_TERMS + 1);
   localparam logic [4:0] MAX_N = 5'(MAX_TERMS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_MULX   = 3'd2;
   localparam logic [2:0] ST_MULR   = 3'd3;
   localparam logic [2:0] ST_FINAL  = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [TC_W-1:0] tc_ff, tc_in;
   logic [NW-1:0]   n_ff, n_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [4:0]      n_sel;
   logic            last_term;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign tc_in     = csr_valid ? csr_term_count : tc_ff;

   // zero terms counts as one, too many is capped
   always_comb begin
      n_sel = {1'b0, tc_ff};
      if (tc_ff == '0) begin
         n_sel = 5'd1;
      end else if ({1'b0, tc_ff} > MAX_N) begin
         n_sel = MAX_N;
      end
   end

   assign last_term = ((NW'(k_ff) + NW'(1)) == n_ff);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.term = TERM_W'(k_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               n_in     = NW'(n_sel);
               k_in     = KW'(1);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = (n_ff == NW'(1)) ? ST_FINAL : ST_MULX;
         end
         ST_MULX: begin
            cmd.mul_x2 = 1'b1;
            state_in   = ST_MULR;
         end
         ST_MULR: begin
            cmd.mul_rcp = 1'b1;
            if (last_term) begin
               state_in = ST_FINAL;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_MULX;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tc_ff    <= TERM_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         tc_ff    <= tc_in;
      end
      n_ff <= n_in;
      k_ff <= k_in;
   end

   `STSU_ASSERT(a_cmd_onehot, clock, reset,
      $onehot0({cmd.load, cmd.square, cmd.mul_x2, cmd.mul_rcp, cmd.finish}),
      "more than one datapath step issued")
   `STSU_ASSERT(a_term_in_range, clock, reset,
      ((state_ff == ST_MULX) || (state_ff == ST_MULR)) |-> ((NW'(k_ff) < n_ff) && (k_ff != '0)),
      "term index outside series")
   `STSU_ASSERT_NEXT(a_final_waits, clock, reset,
      (state_ff == ST_FINAL) && !status.out_free, state_ff == ST_FINAL,
      "result dropped while output busy")
endmodule
`default_nettype wire

/* hw/rtl/stsu_datapath.sv */
// Datapath of the sinc series unit: shared multiplier, term registers, accumulator, output.
`timescale 1ns / 1ps
`default_nettype none
`include "sinc_taylor_series_unit_assert.svh"
module stsu_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic signed [stsu_pkg::X_W-1:0]  req_x_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [stsu_pkg::Y_W-1:0]       rsp_sinc_value,
   input  wire stsu_pkg::stsu_cmd_type           cmd,
   output stsu_pkg::stsu_status_type             status
);
   import stsu_pkg::*;

   localparam logic [PROD_W-1:0] RND_Q28 = PROD_W'(1) << 27;
   localparam logic [PROD_W-1:0] RND_Q32 = PROD_W'(1) << 31;
   localparam logic [AX_W-1:0]   AX_MAX  = AX_W'(X_LIMIT);

   logic [AX_W-1:0]         ax_ff, ax_in;
   logic [X2_W-1:0]         x2_ff, x2_in;
   logic [P_W-1:0]          p_ff, p_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [Y_W-1:0]   rsp_value_ff, rsp_value_in;

   logic signed [X_W-1:0]   x_clamp, x_neg;
   logic [P_W-1:0]          mul_a;
   logic [RCP_W-1:0]        mul_b;
   logic [PROD_W-1:0]       prod, rounded;
   logic signed [SUM_W-1:0] mag_ext, acc_next, acc_sat;

   always_comb begin
      x_clamp = req_x_value;
      if (req_x_value > X_LIMIT) begin
         x_clamp = X_LIMIT;
      end else if (req_x_value < -X_LIMIT) begin
         x_clamp = -X_LIMIT;
      end
   end
   assign x_neg = -x_clamp;

   // one multiplier serves x*x, mag*x2 and p*recip
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.square) begin
         mul_a = P_W'(ax_ff);
         mul_b = RCP_W'(ax_ff);
      end else if (cmd.mul_x2) begin
         mul_a = P_W'(mag_ff);
         mul_b = x2_ff;
      end else if (cmd.mul_rcp) begin
         mul_a = p_ff;
         mul_b = recip_q32(cmd.term);
      end
   end

   assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign rounded = prod + (cmd.mul_rcp ? RND_Q32 : RND_Q28);

   assign mag_ext  = SUM_W'(mag_ff);
   assign acc_next = neg_ff ? (sum_ff - mag_ext) : (sum_ff + mag_ext);

   always_comb begin
      acc_sat = acc_next;
      if (acc_next > SUM_ONE) begin
         acc_sat = SUM_ONE;
      end else if (acc_next < -SUM_ONE) begin
         acc_sat = -SUM_ONE;
      end
   end

   always_comb begin
      ax_in  = ax_ff;
      x2_in  = x2_ff;
      p_in   = p_ff;
      mag_in = mag_ff;
      sum_in = sum_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         ax_in  = x_clamp[X_W-1] ? AX_W'(x_neg) : AX_W'(x_clamp);
         mag_in = MAG_ONE;
         sum_in = '0;
         neg_in = 1'b0;
      end
      if (cmd.square) begin
         x2_in = rounded[28 +: X2_W];
      end
      // fold the current term in while the next one starts
      if (cmd.mul_x2) begin
         p_in   = rounded[28 +: P_W];
         sum_in = acc_next;
         neg_in = ~neg_ff;
      end
      if (cmd.mul_rcp) begin
         mag_in = rounded[32 +: MAG_W];
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = Y_W'(acc_sat);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff        <= ax_in;
      x2_ff        <= x2_in;
      p_ff         <= p_in;
      mag_ff       <= mag_in;
      sum_ff       <= sum_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sinc_value = rsp_value_ff;

   `STSU_ASSERT_NEXT(a_finish_sets_valid, clock, reset, cmd.finish, rsp_valid_ff,
      "finished result not presented")
   `STSU_ASSERT(a_result_in_range, clock, reset,
      rsp_valid_ff |-> ((rsp_value_ff <= Y_ONE) && (rsp_value_ff >= -Y_ONE)),
      "result beyond unit range")
   `STSU_ASSERT_NEXT(a_arg_clamped, clock, reset, cmd.load, ax_ff <= AX_MAX,
      "argument magnitude beyond pi")
endmodule
`default_nettype wire
